/* rtl/pll_frequency_word_builder_unit_defines.svh */
// Assertion macros shared by the frequency word builder RTL.
`ifndef PLL_FREQUENCY_WORD_BUILDER_UNIT_DEFINES_SVH
`define PLL_FREQUENCY_WORD_BUILDER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PFWB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define PFWB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

/* rtl/pfwb_pkg.sv */
`timescale 1ns / 1ps
package pfwb_pkg;

  localparam int KHZ_W  = 23;
  localparam int WORD_W = 32;

  localparam logic [KHZ_W-1:0] FREQ_MIN_KHZ = 23'd35000;
  localparam logic [KHZ_W-1:0] FREQ_MAX_KHZ = 23'd4400000;

  localparam logic [2:0] DIV_CODE_MAX = 3'd6;

  // Window of clamped kHz values for which the integer-MHz VCO frequency,
  // floor(khz / 1000) << code, lands in 2200..4400. Low bound inclusive,
  // high bound exclusive. Entries past the last code are never used.
  localparam logic [KHZ_W-1:0] WIN_LO [8] = '{
    23'd2200000, 23'd1100000, 23'd550000, 23'd275000,
    23'd138000,  23'd69000,   23'd0,      23'd0
  };
  localparam logic [KHZ_W-1:0] WIN_HI [8] = '{
    23'd4401000, 23'd2201000, 23'd1101000, 23'd551000,
    23'd276000,  23'd138000,  23'd0,       23'd0
  };

  // Reciprocals for divide-by-constant, both taken with a right shift of 34:
  // x / 25 for x below 2^29 and x / 1000 for x below 2^24.
  localparam int          RECIP_SHIFT = 34;
  localparam logic [29:0] RECIP_25    = 30'd687194768;
  localparam logic [29:0] RECIP_1000  = 30'd17179870;

  localparam logic [9:0]  MOD_FULL = 10'd1000;
  localparam logic [10:0] RECIP_5  = 11'd1639;  // x / 5 as (x * 1639) >> 13

  localparam logic [WORD_W-1:0] WORD_RF_OFF  = 32'h00EC801C;
  localparam logic [WORD_W-1:0] WORD_R1_BASE = 32'h08008001;
  localparam logic [WORD_W-1:0] WORD_R4_BASE = 32'h008C803C;
  localparam logic [WORD_W-1:0] WORD_R4_MASK = 32'hFFFFFFE7;

  typedef logic [3:0] step_t;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_TEST,
    OP_INC,
    OP_MUL25,
    OP_MUL1000,
    OP_FRAC,
    OP_RED5,
    OP_RED2,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_FOUND,
    COND_CAN5,
    COND_CAN2
  } cond_t;

  typedef enum logic [1:0] {
    SEL_RF_OFF,
    SEL_R1,
    SEL_R0,
    SEL_R4
  } word_sel_t;

  typedef struct packed {
    op_t       op;
    cond_t     cond;
    step_t     target;
    word_sel_t sel;
    logic      last;
  } ctl_word_t;

  localparam step_t STEP_LOAD    = 4'd0;
  localparam step_t STEP_TEST    = 4'd1;
  localparam step_t STEP_INC     = 4'd2;
  localparam step_t STEP_MUL25   = 4'd3;
  localparam step_t STEP_MUL1000 = 4'd4;
  localparam step_t STEP_FRAC    = 4'd5;
  localparam step_t STEP_RED5    = 4'd6;
  localparam step_t STEP_RED2    = 4'd7;
  localparam step_t STEP_EMIT_OF = 4'd8;
  localparam step_t STEP_EMIT_R1 = 4'd9;
  localparam step_t STEP_EMIT_R0 = 4'd10;
  localparam step_t STEP_EMIT_R4 = 4'd11;

  // Program store: one control word per step. A true condition jumps to
  // the target, otherwise the step counter advances.
  function automatic ctl_word_t ucode(step_t step);
    ctl_word_t w;
    unique case (step)
      STEP_LOAD:    w = '{OP_LOAD,    COND_NONE,   STEP_LOAD,    SEL_RF_OFF, 1'b0};
      STEP_TEST:    w = '{OP_TEST,    COND_FOUND,  STEP_MUL25,   SEL_RF_OFF, 1'b0};
      STEP_INC:     w = '{OP_INC,     COND_ALWAYS, STEP_TEST,    SEL_RF_OFF, 1'b0};
      STEP_MUL25:   w = '{OP_MUL25,   COND_NONE,   STEP_LOAD,    SEL_RF_OFF, 1'b0};
      STEP_MUL1000: w = '{OP_MUL1000, COND_NONE,   STEP_LOAD,    SEL_RF_OFF, 1'b0};
      STEP_FRAC:    w = '{OP_FRAC,    COND_NONE,   STEP_LOAD,    SEL_RF_OFF, 1'b0};
      STEP_RED5:    w = '{OP_RED5,    COND_CAN5,   STEP_RED5,    SEL_RF_OFF, 1'b0};
      STEP_RED2:    w = '{OP_RED2,    COND_CAN2,   STEP_RED2,    SEL_RF_OFF, 1'b0};
      STEP_EMIT_OF: w = '{OP_EMIT,    COND_NONE,   STEP_LOAD,    SEL_RF_OFF, 1'b0};
      STEP_EMIT_R1: w = '{OP_EMIT,    COND_NONE,   STEP_LOAD,    SEL_R1,     1'b0};
      STEP_EMIT_R0: w = '{OP_EMIT,    COND_NONE,   STEP_LOAD,    SEL_R0,     1'b0};
      STEP_EMIT_R4: w = '{OP_EMIT,    COND_ALWAYS, STEP_LOAD,    SEL_R4,     1'b1};
      default:      w = '{OP_TEST,    COND_ALWAYS, STEP_LOAD,    SEL_RF_OFF, 1'b0};
    endcase
    return w;
  endfunction

  // Quotient of a 10-bit value by 5.
  function automatic logic [9:0] div5(logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'(RECIP_5);
    return 10'(p[20:13]);
  endfunction

endpackage

/* rtl/pll_frequency_word_builder_unit.sv */
`timescale 1ns / 1ps
// Frequency word builder: each freq_khz transaction (clamped to 35000..4400000 kHz)
// yields four 32-bit synthesizer words in order: RF-off, R1 (modulus), R0 (INT and
// FRAC), R4 (output divider code); last_word marks the fourth. A small microcode
// program steps one shared 30x30 multiplier and a few registers: 1 load step,
// one test step per divider code tried plus one increment step per code passed
// over (1 to 13), 3 arithmetic steps, one step per divide-by-5 or divide-by-2
// reduction plus one each (2 to 8), and 4 emit steps, so 11 to 29 steps per
// transaction; emit steps wait while the output is stalled.
// A new frequency is taken only at the load step.
`include "pll_frequency_word_builder_unit_defines.svh"

module pll_frequency_word_builder_unit
  import pfwb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                freq_valid,
  output logic                freq_stall,
  input  logic [KHZ_W-1:0]    freq_khz,
  output logic                word_valid,
  input  logic                word_stall,
  output logic [WORD_W-1:0]   reg_word,
  output logic                last_word
);

  step_t     pc;
  step_t     pc_next;
  ctl_word_t ctl;

  logic [KHZ_W-1:0] khz_q;
  logic [2:0]       code_q;
  logic [23:0]      acc_q;
  logic [13:0]      int_q;
  logic [9:0]       frac_q;
  logic [9:0]       mod_q;

  logic [KHZ_W-1:0]  khz_clamped;
  logic [28:0]       khz_shifted;
  logic [29:0]       mul_a;
  logic [29:0]       mul_b;
  logic [58:0]       prod;
  logic [23:0]       frac_wide;
  logic [9:0]        frac_div5;
  logic [9:0]        mod_div5;
  logic              found;
  logic              can5;
  logic              can2;
  logic              slot_free;
  logic              hold;
  logic              cond_true;
  logic [WORD_W-1:0] word_sel_val;

  assign ctl = ucode(pc);

  always_comb begin
    khz_clamped = freq_khz;
    if (freq_khz < FREQ_MIN_KHZ) begin
      khz_clamped = FREQ_MIN_KHZ;
    end else if (freq_khz > FREQ_MAX_KHZ) begin
      khz_clamped = FREQ_MAX_KHZ;
    end
  end

  assign found = (code_q == DIV_CODE_MAX) ||
                 ((khz_q >= WIN_LO[code_q]) && (khz_q < WIN_HI[code_q]));

  // Shared multiplier: reciprocal of 25 on the shifted frequency, or of 1000 on acc_q.
  assign khz_shifted = 29'(khz_q) << code_q;
  assign mul_a = (ctl.op == OP_MUL1000) ? 30'(acc_q) : 30'(khz_shifted);
  assign mul_b = (ctl.op == OP_MUL1000) ? RECIP_1000 : RECIP_25;
  assign prod  = 59'(mul_a) * 59'(mul_b);

  assign frac_wide = acc_q - (24'(int_q) * 24'd1000);

  assign frac_div5 = div5(frac_q);
  assign mod_div5  = div5(mod_q);
  assign can5 = ((12'(frac_div5) * 12'd5) == 12'(frac_q)) &&
                ((12'(mod_div5) * 12'd5) == 12'(mod_q));
  assign can2 = !frac_q[0] && !mod_q[0];

  assign slot_free  = !word_valid || !word_stall;
  assign freq_stall = (ctl.op != OP_LOAD);

  always_comb begin
    case (ctl.cond)
      COND_ALWAYS: cond_true = 1'b1;
      COND_FOUND:  cond_true = found;
      COND_CAN5:   cond_true = can5;
      COND_CAN2:   cond_true = can2;
      default:     cond_true = 1'b0;
    endcase
  end

  // Hold on the load step until a frequency arrives and on emit steps until the
  // output register frees up.
  assign hold = ((ctl.op == OP_LOAD) && !freq_valid) ||
                ((ctl.op == OP_EMIT) && !slot_free);

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (cond_true) begin
      pc_next = ctl.target;
    end else begin
      pc_next = pc + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        if (freq_valid) begin
          khz_q  <= khz_clamped;
          code_q <= '0;
        end
      end
      OP_INC:     code_q <= code_q + 3'd1;
      OP_MUL25:   acc_q  <= prod[RECIP_SHIFT+23:RECIP_SHIFT];
      OP_MUL1000: int_q  <= prod[RECIP_SHIFT+13:RECIP_SHIFT];
      OP_FRAC: begin
        frac_q <= frac_wide[9:0];
        mod_q  <= MOD_FULL;
      end
      OP_RED5: begin
        if (can5) begin
          frac_q <= frac_div5;
          mod_q  <= mod_div5;
        end
      end
      OP_RED2: begin
        if (can2) begin
          frac_q <= frac_q >> 1;
          mod_q  <= mod_q >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (ctl.sel)
      SEL_RF_OFF: word_sel_val = WORD_RF_OFF;
      SEL_R1:     word_sel_val = WORD_R1_BASE + {19'd0, mod_q, 3'd0};
      SEL_R0:     word_sel_val = {3'd0, int_q, 15'd0} + {19'd0, frac_q, 3'd0};
      SEL_R4:     word_sel_val = (WORD_R4_BASE + {9'd0, code_q, 20'd0}) & WORD_R4_MASK;
      default:    word_sel_val = WORD_RF_OFF;
    endcase
  end

  // Output register: load on an emit step when free, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if ((ctl.op == OP_EMIT) && slot_free) begin
      word_valid <= 1'b1;
    end else if (!word_stall) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctl.op == OP_EMIT) && slot_free) begin
      reg_word  <= word_sel_val;
      last_word <= ctl.last;
    end
  end

  `PFWB_ASSERT_NXT(a_accept_starts_search, clk, rst, freq_valid && !freq_stall, pc == STEP_TEST)
  `PFWB_ASSERT_IMP(a_idle_holds_last_only, clk, rst, (ctl.op == OP_LOAD) && word_valid, last_word)
  `PFWB_ASSERT_IMP(a_divider_found, clk, rst, ctl.op == OP_MUL25, found)
  `PFWB_ASSERT_IMP(a_frac_below_mod, clk, rst, ctl.op == OP_EMIT, frac_q < mod_q)

endmodule
